>>> src/gbcs_pkg.sv
package gbcs_pkg;

  // Grid and point-space geometry
  localparam int GRID_BITS  = 8;
  localparam int POINT_BITS = 22;

  // Field widths
  localparam int CMD_W   = 2;
  localparam int COORD_W = 32;
  localparam int IDX_W   = 16;
  localparam int RANK_W  = 16;
  localparam int CNT_W   = 16;
  localparam int DEST_W  = POINT_BITS;
  localparam int TOT_W   = POINT_BITS + 1;

  // Cell address width inside the block
  localparam int CELL_W = 2 * GRID_BITS;

  // Width of the shared saturating adder
  localparam int ALU_W = (TOT_W > CNT_W) ? TOT_W : CNT_W;

  // Saturation limits on the adder's scale
  localparam logic [ALU_W-1:0] CNT_MAX   = ALU_W'({CNT_W{1'b1}});
  localparam logic [ALU_W-1:0] TOTAL_CAP = ALU_W'(1) << POINT_BITS;
  localparam logic [ALU_W-1:0] DEST_MAX  = TOTAL_CAP - ALU_W'(1);

  // Last cell address
  localparam logic [CELL_W-1:0] CELL_LAST = {CELL_W{1'b1}};

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_BIN   = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_PLACE = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

endpackage

>>> src/gbcs_if.sv
interface gbcs_in_if;
  logic                         valid;
  logic                         ready;
  logic [gbcs_pkg::CMD_W-1:0]   cmd;
  logic [gbcs_pkg::COORD_W-1:0] coord_x;
  logic [gbcs_pkg::COORD_W-1:0] coord_y;
  logic [gbcs_pkg::IDX_W-1:0]   place_cell;
  logic [gbcs_pkg::RANK_W-1:0]  place_rank;

  modport source (
    output valid, cmd, coord_x, coord_y, place_cell, place_rank,
    input  ready
  );
  modport sink (
    input  valid, cmd, coord_x, coord_y, place_cell, place_rank,
    output ready
  );
endinterface

interface gbcs_out_if;
  logic                        valid;
  logic                        ready;
  logic [gbcs_pkg::IDX_W-1:0]  bin_index;
  logic [gbcs_pkg::RANK_W-1:0] rank_in_cell;
  logic [gbcs_pkg::DEST_W-1:0] dest_address;
  logic [gbcs_pkg::TOT_W-1:0]  total_points;
  logic                        overflow;

  modport source (
    output valid, bin_index, rank_in_cell, dest_address, total_points, overflow,
    input  ready
  );
  modport sink (
    input  valid, bin_index, rank_in_cell, dest_address, total_points, overflow,
    output ready
  );
endinterface

>>> src/gbcs_ram.sv
module gbcs_ram #(
  parameter int WIDTH  = 16,
  parameter int ADDR_W = 16
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [2**ADDR_W];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/gbcs_sat_add.sv
module gbcs_sat_add (
  input  logic [gbcs_pkg::ALU_W-1:0]  a_i,
  input  logic [gbcs_pkg::CNT_W-1:0]  b_i,
  input  logic [gbcs_pkg::ALU_W-1:0]  cap_i,
  output logic [gbcs_pkg::ALU_W-1:0]  res_o,
  output logic                        sat_o
);

  logic [gbcs_pkg::ALU_W:0] sum;

  // Add, compare against the cap, clamp
  always_comb begin
    sum   = {1'b0, a_i} + (gbcs_pkg::ALU_W + 1)'(b_i);
    sat_o = sum > {1'b0, cap_i};
    res_o = sat_o ? cap_i : sum[gbcs_pkg::ALU_W-1:0];
  end

endmodule

>>> src/grid_bin_counting_sort.sv
// Channel   Dir  Modport  Payload
// in_i      in   sink     cmd, coord_x, coord_y, place_cell, place_rank
// out_o     out  source   bin_index, rank_in_cell, dest_address, total_points, overflow
//
// Bin and place items read the cell's memory word, update through the shared
// saturating adder, then load the output.
// Allocate streams one cell per cycle through the count memory's read port and
// the adder. A no-operation item is accepted and gives no result.
// After reset a clearing pass zeroes the count memory, one cell per cycle,
// with in_i.ready low.
// A result waits in the output register; a finished item stalls in the result
// registers until that register is free, and in_i.ready is high only when idle.
module grid_bin_counting_sort (
  input  logic       clk_i,
  input  logic       rst_ni,
  gbcs_in_if.sink    in_i,
  gbcs_out_if.source out_o
);

  typedef enum logic [7:0] {
    S_CLEAR    = 8'b0000_0001,
    S_IDLE     = 8'b0000_0010,
    S_BIN_RD   = 8'b0000_0100,
    S_BIN_WR   = 8'b0000_1000,
    S_PLACE_RD = 8'b0001_0000,
    S_PLACE_WR = 8'b0010_0000,
    S_ALLOC    = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // Item registers
  logic [gbcs_pkg::CELL_W-1:0] addr_q;
  logic [gbcs_pkg::RANK_W-1:0] rank_q;
  logic [gbcs_pkg::CELL_W-1:0] idx_q;
  logic [gbcs_pkg::CELL_W-1:0] acc_idx_q;
  logic                        issued_all_q;
  logic                        pend_q;
  logic [gbcs_pkg::TOT_W-1:0]  sum_q;

  // Result of the item in flight
  logic [gbcs_pkg::IDX_W-1:0]  res_cell_q;
  logic [gbcs_pkg::RANK_W-1:0] res_rank_q;
  logic [gbcs_pkg::DEST_W-1:0] res_dest_q;
  logic [gbcs_pkg::TOT_W-1:0]  res_total_q;
  logic                        res_ovf_q;

  // Output register
  logic                        out_valid_q;
  logic [gbcs_pkg::IDX_W-1:0]  out_cell_q;
  logic [gbcs_pkg::RANK_W-1:0] out_rank_q;
  logic [gbcs_pkg::DEST_W-1:0] out_dest_q;
  logic [gbcs_pkg::TOT_W-1:0]  out_total_q;
  logic                        out_ovf_q;

  logic                        in_acc;
  logic                        out_free;
  logic [gbcs_pkg::CELL_W-1:0] bin_cell;

  // Memory ports
  logic                        cnt_we, cnt_re;
  logic [gbcs_pkg::CELL_W-1:0] cnt_waddr, cnt_raddr;
  logic [gbcs_pkg::CNT_W-1:0]  cnt_wdata, cnt_rdata;
  logic                        base_we, base_re;
  logic [gbcs_pkg::TOT_W-1:0]  base_rdata;

  // Shared adder
  logic [gbcs_pkg::ALU_W-1:0]  alu_a, alu_cap, alu_res;
  logic [gbcs_pkg::CNT_W-1:0]  alu_b;
  logic                        alu_sat;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign bin_cell   = {in_i.coord_y[gbcs_pkg::COORD_W-1 -: gbcs_pkg::GRID_BITS],
                       in_i.coord_x[gbcs_pkg::COORD_W-1 -: gbcs_pkg::GRID_BITS]};

  // Pick adder operands for the active step
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_cap = '0;
    case (state_q)
      S_BIN_WR: begin
        alu_a   = gbcs_pkg::ALU_W'(cnt_rdata);
        alu_b   = gbcs_pkg::CNT_W'(1);
        alu_cap = gbcs_pkg::CNT_MAX;
      end
      S_PLACE_WR: begin
        alu_a   = gbcs_pkg::ALU_W'(base_rdata);
        alu_b   = rank_q;
        alu_cap = gbcs_pkg::DEST_MAX;
      end
      S_ALLOC: begin
        alu_a   = gbcs_pkg::ALU_W'(sum_q);
        alu_b   = cnt_rdata;
        alu_cap = gbcs_pkg::TOTAL_CAP;
      end
      default: begin
        alu_a   = '0;
      end
    endcase
  end

  gbcs_sat_add u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .cap_i (alu_cap),
    .res_o (alu_res),
    .sat_o (alu_sat)
  );

  // Count memory access
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = addr_q;
    cnt_wdata = '0;
    cnt_re    = 1'b0;
    cnt_raddr = addr_q;
    case (state_q)
      S_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = idx_q;
      end
      S_BIN_RD: begin
        cnt_re = 1'b1;
      end
      S_BIN_WR: begin
        cnt_we    = 1'b1;
        cnt_wdata = alu_res[gbcs_pkg::CNT_W-1:0];
      end
      S_PLACE_WR: begin
        cnt_we = (rank_q == '0);
      end
      S_ALLOC: begin
        cnt_re    = !issued_all_q;
        cnt_raddr = idx_q;
      end
      default: begin
        cnt_we = 1'b0;
      end
    endcase
  end

  assign base_we = (state_q == S_ALLOC) && pend_q;
  assign base_re = (state_q == S_PLACE_RD);

  gbcs_ram #(
    .WIDTH  (gbcs_pkg::CNT_W),
    .ADDR_W (gbcs_pkg::CELL_W)
  ) u_counts (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (cnt_re),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  gbcs_ram #(
    .WIDTH  (gbcs_pkg::TOT_W),
    .ADDR_W (gbcs_pkg::CELL_W)
  ) u_bases (
    .clk_i   (clk_i),
    .we_i    (base_we),
    .waddr_i (acc_idx_q),
    .wdata_i (sum_q),
    .re_i    (base_re),
    .raddr_i (addr_q),
    .rdata_o (base_rdata)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (idx_q == gbcs_pkg::CELL_LAST) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          case (in_i.cmd)
            gbcs_pkg::CMD_BIN:   state_d = S_BIN_RD;
            gbcs_pkg::CMD_ALLOC: state_d = S_ALLOC;
            gbcs_pkg::CMD_PLACE: state_d = S_PLACE_RD;
            default:             state_d = S_IDLE;
          endcase
        end
      end
      S_BIN_RD:   state_d = S_BIN_WR;
      S_BIN_WR:   state_d = S_DONE;
      S_PLACE_RD: state_d = S_PLACE_WR;
      S_PLACE_WR: state_d = S_DONE;
      S_ALLOC: begin
        if (pend_q && (acc_idx_q == gbcs_pkg::CELL_LAST)) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default:    state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      idx_q        <= '0;
      issued_all_q <= 1'b0;
      pend_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      // Sweep and allocate index
      if (state_q == S_CLEAR) begin
        idx_q <= idx_q + gbcs_pkg::CELL_W'(1);
      end else if (in_acc) begin
        idx_q        <= '0;
        issued_all_q <= 1'b0;
        pend_q       <= 1'b0;
      end else if (state_q == S_ALLOC) begin
        pend_q <= cnt_re;
        if (cnt_re) begin
          idx_q <= idx_q + gbcs_pkg::CELL_W'(1);
          if (idx_q == gbcs_pkg::CELL_LAST) issued_all_q <= 1'b1;
        end
      end

      // Hand the result to the output register, drop it once taken
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      addr_q      <= (in_i.cmd == gbcs_pkg::CMD_BIN) ? bin_cell
                                                     : gbcs_pkg::CELL_W'(in_i.place_cell);
      rank_q      <= in_i.place_rank;
      sum_q       <= '0;
      res_cell_q  <= (in_i.cmd == gbcs_pkg::CMD_BIN) ? gbcs_pkg::IDX_W'(bin_cell) : '0;
      res_rank_q  <= '0;
      res_dest_q  <= '0;
      res_total_q <= '0;
      res_ovf_q   <= 1'b0;
    end

    // Count update on bin
    if (state_q == S_BIN_WR) begin
      res_rank_q <= cnt_rdata;
      res_ovf_q  <= alu_sat;
    end

    // Address on place
    if (state_q == S_PLACE_WR) begin
      res_dest_q <= gbcs_pkg::DEST_W'(alu_res);
      res_ovf_q  <= alu_sat;
    end

    // Running prefix sum on allocate
    if (state_q == S_ALLOC && pend_q) begin
      sum_q       <= gbcs_pkg::TOT_W'(alu_res);
      res_total_q <= gbcs_pkg::TOT_W'(alu_res);
      res_ovf_q   <= res_ovf_q | alu_sat;
    end
    if (state_q == S_ALLOC && cnt_re) begin
      acc_idx_q <= idx_q;
    end

    // Load the output beat
    if (state_q == S_DONE && out_free) begin
      out_cell_q  <= res_cell_q;
      out_rank_q  <= res_rank_q;
      out_dest_q  <= res_dest_q;
      out_total_q <= res_total_q;
      out_ovf_q   <= res_ovf_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.bin_index    = out_cell_q;
  assign out_o.rank_in_cell = out_rank_q;
  assign out_o.dest_address = out_dest_q;
  assign out_o.total_points = out_total_q;
  assign out_o.overflow     = out_ovf_q;

  // Any real command takes the block out of idle in the cycle after it is accepted
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_i.cmd != gbcs_pkg::CMD_NOP) |=> state_q != S_IDLE)
    else $error("block idle right after accepting a command");

  // Prefix sum never passes the cap
  a_sum_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ALLOC) |-> gbcs_pkg::ALU_W'(sum_q) <= gbcs_pkg::TOTAL_CAP)
    else $error("allocate sum above cap");

  // Output beats come only from the finishing step
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("output loaded outside the finishing step");

  // A place write only clears a counter
  a_place_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PLACE_WR) && cnt_we |-> cnt_wdata == '0)
    else $error("place wrote a nonzero count");

  // A bin never lowers a counter
  a_bin_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BIN_WR) |-> cnt_wdata >= cnt_rdata)
    else $error("bin lowered a count");

endmodule

>>> tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_CELLS = 1 << gbcs_pkg::CELL_W;

  typedef struct packed {
    gbcs_pkg::cmd_e               cmd;
    logic [gbcs_pkg::COORD_W-1:0] coord_x;
    logic [gbcs_pkg::COORD_W-1:0] coord_y;
    logic [gbcs_pkg::IDX_W-1:0]   place_cell;
    logic [gbcs_pkg::RANK_W-1:0]  place_rank;
  } in_beat_t;

  typedef struct packed {
    logic [gbcs_pkg::IDX_W-1:0]  bin_index;
    logic [gbcs_pkg::RANK_W-1:0] rank_in_cell;
    logic [gbcs_pkg::DEST_W-1:0] dest_address;
    logic [gbcs_pkg::TOT_W-1:0]  total_points;
    logic                        overflow;
  } out_beat_t;

  // Shadow of the per-cell counters and bases, plus the answers still owed
  class cell_tally;
    logic [gbcs_pkg::CNT_W-1:0] tally   [NUM_CELLS];
    logic [gbcs_pkg::TOT_W-1:0] base_of [NUM_CELLS];
    out_beat_t        due_results[$];
    int errors;
    int n_checked;
    int n_bin;
    int n_alloc;
    int n_place;
    int n_nop;
    int n_full;

    function new();
      foreach (tally[i]) tally[i] = '0;
      foreach (base_of[i]) base_of[i] = '0;
    endfunction

    // Work out the answer to an accepted beat and advance the shadow state
    function bit take_item(input in_beat_t b, output out_beat_t r);
      logic [gbcs_pkg::CELL_W-1:0] slot;
      longint unsigned             acc;
      r = '0;
      case (b.cmd)
        gbcs_pkg::CMD_BIN: begin
          slot = {b.coord_y[gbcs_pkg::COORD_W-1 -: gbcs_pkg::GRID_BITS],
                  b.coord_x[gbcs_pkg::COORD_W-1 -: gbcs_pkg::GRID_BITS]};
          r.bin_index    = gbcs_pkg::IDX_W'(slot);
          r.rank_in_cell = gbcs_pkg::RANK_W'(tally[slot]);
          if (tally[slot] == {gbcs_pkg::CNT_W{1'b1}}) begin
            r.overflow = 1'b1;
            n_full++;
          end else begin
            tally[slot] = tally[slot] + 1'b1;
          end
          n_bin++;
        end
        gbcs_pkg::CMD_ALLOC: begin
          // Exclusive prefix sum, clamped at the point-space size
          acc = 0;
          for (int i = 0; i < NUM_CELLS; i++) begin
            base_of[i] = gbcs_pkg::TOT_W'(acc);
            acc += 64'(tally[i]);
            if (acc > 64'(gbcs_pkg::TOTAL_CAP)) begin
              acc        = 64'(gbcs_pkg::TOTAL_CAP);
              r.overflow = 1'b1;
            end
          end
          r.total_points = gbcs_pkg::TOT_W'(acc);
          n_alloc++;
        end
        gbcs_pkg::CMD_PLACE: begin
          slot = gbcs_pkg::CELL_W'(b.place_cell);
          acc  = 64'(base_of[slot]);
          acc += 64'(b.place_rank);
          if (acc > 64'(gbcs_pkg::DEST_MAX)) begin
            acc        = 64'(gbcs_pkg::DEST_MAX);
            r.overflow = 1'b1;
          end
          // Rank zero hands the cell back empty for the next frame
          if (b.place_rank == '0) tally[slot] = '0;
          r.dest_address = gbcs_pkg::DEST_W'(acc);
          n_place++;
        end
        default: begin
          n_nop++;
          return 1'b0;
        end
      endcase
      due_results.push_back(r);
      return 1'b1;
    endfunction

    function void flag(input string msg);
      errors++;
      $display("%s", msg);
    endfunction

    function void field(input string name, input longint unsigned want,
                        input longint unsigned got);
      if (want !== got)
        flag($sformatf("%0t: %s expected 0x%0h got 0x%0h", $time, name, want, got));
    endfunction

    // Compare a result beat with the oldest answer owed
    function void check_result(input out_beat_t got);
      out_beat_t want;
      if (due_results.size() == 0) begin
        flag($sformatf({"%0t: result beat expected none got idx 0x%0h rank 0x%0h",
                        " dest 0x%0h tot 0x%0h ovf %b"},
                       $time, got.bin_index, got.rank_in_cell, got.dest_address,
                       got.total_points, got.overflow));
        return;
      end
      want = due_results.pop_front();
      n_checked++;
      field("bin_index", want.bin_index, got.bin_index);
      field("rank_in_cell", want.rank_in_cell, got.rank_in_cell);
      field("dest_address", want.dest_address, got.dest_address);
      field("total_points", want.total_points, got.total_points);
      field("overflow", want.overflow, got.overflow);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  gbcs_in_if  in_if ();
  gbcs_out_if out_if ();

  grid_bin_counting_sort i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  cell_tally sb = new();

  int        burst_left = 0;
  int        rx_mode    = 0;
  int        rx_span    = 0;
  int        rx_tick    = 0;
  out_beat_t last_answer;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Receiver: stall on one of four patterns, picked anew at random when each span runs out
  initial begin
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (rx_span == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_span = $urandom_range(20, 300);
      end
      rx_span--;
      rx_tick++;
      case (rx_mode)
        0:       out_if.ready <= 1'b1;
        1:       out_if.ready <= ($urandom_range(0, 99) < 60);
        2:       out_if.ready <= (rx_tick % 5 == 0);
        default: out_if.ready <= (rx_tick % 16 >= 10);
      endcase
    end
  end

  // Check each result beat as it leaves
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1)
      sb.check_result(out_beat_t'{out_if.bin_index, out_if.rank_in_cell,
                                  out_if.dest_address, out_if.total_points,
                                  out_if.overflow});
  end

  function automatic in_beat_t op_beat(input gbcs_pkg::cmd_e c);
    in_beat_t b;
    b.cmd        = c;
    b.coord_x    = gbcs_pkg::COORD_W'($urandom);
    b.coord_y    = gbcs_pkg::COORD_W'($urandom);
    b.place_cell = gbcs_pkg::IDX_W'($urandom);
    b.place_rank = gbcs_pkg::RANK_W'($urandom);
    return b;
  endfunction

  function automatic in_beat_t bin_beat(input logic [gbcs_pkg::COORD_W-1:0] x,
                                        input logic [gbcs_pkg::COORD_W-1:0] y);
    in_beat_t b;
    b         = op_beat(gbcs_pkg::CMD_BIN);
    b.coord_x = x;
    b.coord_y = y;
    return b;
  endfunction

  function automatic in_beat_t place_beat(input logic [gbcs_pkg::IDX_W-1:0] c,
                                          input logic [gbcs_pkg::RANK_W-1:0] r);
    in_beat_t b;
    b            = op_beat(gbcs_pkg::CMD_PLACE);
    b.place_cell = c;
    b.place_rank = r;
    return b;
  endfunction

  // Stray beat: a bin nobody places, a place on any cell, or an idle command
  function automatic in_beat_t noise_beat();
    int pick;
    pick = $urandom_range(0, 2);
    if (pick == 0) return op_beat(gbcs_pkg::CMD_BIN);
    if (pick == 1) return op_beat(gbcs_pkg::CMD_PLACE);
    return op_beat(gbcs_pkg::CMD_NOP);
  endfunction

  // Present one beat and hold it until the block takes it
  task automatic put_beat(input in_beat_t b);
    out_beat_t r;
    in_if.valid      <= 1'b1;
    in_if.cmd        <= b.cmd;
    in_if.coord_x    <= b.coord_x;
    in_if.coord_y    <= b.coord_y;
    in_if.place_cell <= b.place_cell;
    in_if.place_rank <= b.place_rank;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    if (sb.take_item(b, r)) last_answer = r;
  endtask

  // Send in bursts of random length with random gaps between them
  task automatic send(input in_beat_t b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    if (burst_left > 0) burst_left--;
    put_beat(b);
  endtask

  // Hold off until every owed result has come out
  task automatic settle();
    in_if.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (sb.due_results.size() != 0);
  endtask

  task automatic run_directed();
    send(bin_beat('0, '0));
    send(bin_beat('1, '1));
    send(bin_beat('1, '0));
    send(bin_beat('0, '1));
    // Low bits set, top bits clear: same cell as the origin
    send(bin_beat(32'h00FF_FFFF, 32'h00FF_FFFF));
    send(bin_beat(32'h00FF_FFFF, 32'h0000_0000));
    send(in_beat_t'{gbcs_pkg::CMD_NOP, '1, '1, '1, '1});
    send(op_beat(gbcs_pkg::CMD_ALLOC));
    send(place_beat(16'h0000, 16'h0002));
    send(place_beat(16'h0000, 16'hFFFF));
    send(place_beat(16'hFFFF, 16'h0000));
    send(place_beat(16'hFF00, 16'h0000));
    send(place_beat(16'h00FF, 16'h0000));
    send(place_beat(16'h0000, 16'h0000));
    send(place_beat(16'h5555, 16'hAAAA));
    send(place_beat(16'hAAAA, 16'h5555));
    send(bin_beat('0, '0));
    send(in_beat_t'{gbcs_pkg::CMD_NOP, '0, '0, '0, '0});
    send(bin_beat(32'hAAAA_AAAA, 32'h5555_5555));
  endtask

  // One frame: bin clustered points, allocate, then place them all
  task automatic run_frame(input int n);
    logic [gbcs_pkg::GRID_BITS-1:0] hot_x [4];
    logic [gbcs_pkg::GRID_BITS-1:0] hot_y [4];
    logic [gbcs_pkg::COORD_W-1:0]   x;
    logic [gbcs_pkg::COORD_W-1:0]   y;
    out_beat_t                      pts[$];
    out_beat_t                      t;
    int                             k;
    int                             j;
    foreach (hot_x[i]) begin
      hot_x[i] = gbcs_pkg::GRID_BITS'($urandom);
      hot_y[i] = gbcs_pkg::GRID_BITS'($urandom);
    end
    repeat (n) begin
      if ($urandom_range(0, 99) < 10) begin
        send(noise_beat());
      end else begin
        x = gbcs_pkg::COORD_W'($urandom);
        y = gbcs_pkg::COORD_W'($urandom);
        if ($urandom_range(0, 3) != 0) begin
          k = $urandom_range(0, 3);
          x[gbcs_pkg::COORD_W-1 -: gbcs_pkg::GRID_BITS] = hot_x[k];
          y[gbcs_pkg::COORD_W-1 -: gbcs_pkg::GRID_BITS] = hot_y[k];
        end
        send(bin_beat(x, y));
        pts.push_back(last_answer);
      end
    end
    send(op_beat(gbcs_pkg::CMD_ALLOC));
    // Place in shuffled order
    for (int i = pts.size() - 1; i > 0; i--) begin
      j      = $urandom_range(0, i);
      t      = pts[i];
      pts[i] = pts[j];
      pts[j] = t;
    end
    foreach (pts[i]) begin
      if ($urandom_range(0, 99) < 8) send(noise_beat());
      send(place_beat(pts[i].bin_index, pts[i].rank_in_cell));
    end
  endtask

  initial begin
    in_if.valid      <= 1'b0;
    in_if.cmd        <= gbcs_pkg::CMD_NOP;
    in_if.coord_x    <= '0;
    in_if.coord_y    <= '0;
    in_if.place_cell <= '0;
    in_if.place_rank <= '0;
    rst_ni           <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    settle();
    for (int f = 0; f < 4; f++) begin
      run_frame($urandom_range(40, 56));
      if (f == 1) settle();
    end

    // Drain, then keep the clock running so the block can still misbehave
    in_if.valid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("ran %0d bin, %0d allocate, %0d place and %0d idle commands",
             sb.n_bin, sb.n_alloc, sb.n_place, sb.n_nop);
    $display("%0d results checked, %0d bins landed on a full counter, %0d mismatches",
             sb.n_checked, sb.n_full, sb.errors);
    if (sb.errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(50_000_000);
    $display("timeout with %0d results outstanding", sb.due_results.size());
    $display("tb NOT OK");
    $finish;
  end

endmodule
